// ===== rtl/ipx_pkg.sv =====
// Shared types and constants for the iterated page expander.
// No dependencies; imported by every ipx module and the top level.
package ipx_pkg;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int COUNT_W        = 13;
  localparam int LEN_W          = 16;
  localparam int BYTE_W         = 8;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FEED  = 2'd1,
    OP_PULL  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_BYTE     = 3'd1,
    ST_NEED     = 3'd2,
    ST_BUSY     = 3'd3,
    ST_DONE     = 3'd4,
    ST_ERROR    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PATTERN = 3'd2,
    PH_EMIT    = 3'd3,
    PH_DONE    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  // Result of one transaction, minus the byte that comes from the store.
  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic                 is_byte;
  } res_t;

  // Store access strobes.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== rtl/ipx_store.sv =====
// Pattern store: one write port, one registered read port.
// Depends on ipx_pkg.
module ipx_store #(
  parameter int PAGE_BYTES = ipx_pkg::PAGE_BYTES_DEF
) (
  input  logic                          clk,
  input  ipx_pkg::mem_ctl_t             ctl,
  input  logic [$clog2(PAGE_BYTES)-1:0] addr,
  input  logic [ipx_pkg::BYTE_W-1:0]    wdata,
  output logic [ipx_pkg::BYTE_W-1:0]    rdata
);
  import ipx_pkg::*;

  logic [BYTE_W-1:0] mem_r [PAGE_BYTES];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[addr] <= wdata;
    end
  end

  // Read data held until the next read, so a stalled result keeps its byte.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ipx_ctrl.sv =====
// Page parse/expand control: phase machine, header assembly, counters,
// store write/read requests. Depends on ipx_pkg.
module ipx_ctrl #(
  parameter int PAGE_BYTES = ipx_pkg::PAGE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [1:0]                    opcode,
  input  logic [ipx_pkg::LEN_W-1:0]     src_len,
  input  logic [ipx_pkg::BYTE_W-1:0]    src_byte,
  output ipx_pkg::res_t                 res,
  output ipx_pkg::mem_ctl_t             mem_ctl,
  output logic [$clog2(PAGE_BYTES)-1:0] mem_addr,
  output logic [ipx_pkg::BYTE_W-1:0]    mem_wdata
);
  import ipx_pkg::*;

  localparam int AW = $clog2(PAGE_BYTES);
  localparam int CW = $clog2(PAGE_BYTES + 1);
  localparam logic [CW-1:0] PAGE_C = CW'(PAGE_BYTES);

  phase_t             phase_r, phase_nxt;
  logic [23:0]        hdr_r, hdr_nxt;
  logic [1:0]         hidx_r, hidx_nxt;
  logic [LEN_W-1:0]   plen_r, plen_nxt;
  logic [LEN_W-1:0]   reps_r, reps_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [LEN_W-1:0]   taken_r, taken_nxt;
  logic [LEN_W-1:0]   slen_r, slen_nxt;
  logic [CW-1:0]      total_r, total_nxt;

  op_t                op;
  logic               in_src;
  logic               have_src;
  logic               absorb;
  logic [BYTE_W-1:0]  ab;
  logic [LEN_W-1:0]   h_count;
  logic [LEN_W-1:0]   h_len;
  logic [31:0]        h_prod;
  logic [CW-1:0]      room;
  logic               hdr_last;
  logic               pat_last;
  logic               emit_pull;
  logic               big_page;

  assign op        = op_t'(opcode);
  assign in_src    = (phase_r == PH_HEADER) || (phase_r == PH_PATTERN);
  assign have_src  = taken_r < slen_r;
  assign absorb    = acc && in_src &&
                     (((op == OP_FEED) && have_src) || ((op == OP_PULL) && !have_src));
  assign ab        = (op == OP_FEED) ? src_byte : '0;
  assign hdr_last  = (hidx_r == 2'd3);
  assign h_count   = hdr_r[15:0];
  assign h_len     = {ab, hdr_r[23:16]};
  assign h_prod    = h_count * h_len;
  assign room      = PAGE_C - total_r;
  assign pat_last  = (32'(pos_r) + 32'd1) >= 32'(plen_r);
  assign emit_pull = acc && (op == OP_PULL) && (phase_r == PH_EMIT);
  assign big_page  = 32'(src_len) >= 32'(PAGE_BYTES);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc && (op == OP_START)) begin
      phase_nxt = big_page ? PH_DONE : PH_HEADER;
    end else if (absorb && (phase_r == PH_HEADER) && hdr_last) begin
      if (h_count == '0) begin
        phase_nxt = PH_DONE;
      end else if (h_len == '0) begin
        phase_nxt = PH_HEADER;
      end else if (h_prod > 32'(room)) begin
        phase_nxt = PH_ERROR;
      end else begin
        phase_nxt = PH_PATTERN;
      end
    end else if (absorb && (phase_r == PH_PATTERN) && pat_last) begin
      phase_nxt = PH_EMIT;
    end else if (emit_pull && pat_last && (reps_r == LEN_W'(1))) begin
      phase_nxt = PH_HEADER;
    end
  end

  // Datapath registers, result and store requests
  always_comb begin
    hdr_nxt    = hdr_r;
    hidx_nxt   = hidx_r;
    plen_nxt   = plen_r;
    reps_nxt   = reps_r;
    pos_nxt    = pos_r;
    taken_nxt  = taken_r;
    slen_nxt   = slen_r;
    total_nxt  = total_r;
    mem_ctl    = '0;
    mem_addr   = pos_r;
    mem_wdata  = ab;
    res.status = ST_BUSY;
    res.is_byte = 1'b0;

    if (acc) begin
      unique case (op)
        OP_START: begin
          taken_nxt  = '0;
          slen_nxt   = src_len;
          total_nxt  = '0;
          reps_nxt   = '0;
          plen_nxt   = '0;
          pos_nxt    = '0;
          hdr_nxt    = '0;
          hidx_nxt   = '0;
          res.status = big_page ? ST_DONE : ST_ACCEPTED;
        end
        OP_FEED: begin
          if (in_src && have_src) res.status = ST_ACCEPTED;
        end
        OP_PULL: begin
          case (phase_r) inside
            PH_HEADER, PH_PATTERN: res.status = have_src ? ST_NEED : ST_BUSY;
            PH_EMIT: begin
              res.status   = ST_BYTE;
              res.is_byte  = 1'b1;
              mem_ctl.rd_en = 1'b1;
              total_nxt    = total_r + CW'(1);
              pos_nxt      = pos_r + AW'(1);
              if (pat_last) begin
                pos_nxt  = '0;
                reps_nxt = reps_r - LEN_W'(1);
                if (reps_r == LEN_W'(1)) begin
                  hdr_nxt  = '0;
                  hidx_nxt = '0;
                end
              end
            end
            PH_DONE: res.status = ST_DONE;
            default: res.status = ST_ERROR;
          endcase
        end
        default: res.status = ST_BUSY;
      endcase

      if (absorb) begin
        if (op == OP_FEED) taken_nxt = taken_r + LEN_W'(1);
        if (phase_r == PH_HEADER) begin
          hidx_nxt = hidx_r + 2'd1;
          case (hidx_r)
            2'd0:    hdr_nxt[7:0]   = ab;
            2'd1:    hdr_nxt[15:8]  = ab;
            2'd2:    hdr_nxt[23:16] = ab;
            default: begin
              reps_nxt = h_count;
              plen_nxt = h_len;
              pos_nxt  = '0;
              hdr_nxt  = '0;
            end
          endcase
        end else begin
          mem_ctl.wr_en = 1'b1;
          pos_nxt = pat_last ? '0 : pos_r + AW'(1);
        end
      end
    end
    res.count = COUNT_W'(total_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hdr_r   <= '0;
      hidx_r  <= '0;
      plen_r  <= '0;
      reps_r  <= '0;
      pos_r   <= '0;
      taken_r <= '0;
      slen_r  <= '0;
      total_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      hidx_r  <= hidx_nxt;
      plen_r  <= plen_nxt;
      reps_r  <= reps_nxt;
      pos_r   <= pos_nxt;
      taken_r <= taken_nxt;
      slen_r  <= slen_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

// ===== rtl/ipx_out.sv =====
// Result pipeline: one stage aligned with the store read, then the output
// register. Depends on ipx_pkg.
module ipx_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  ipx_pkg::res_t                res,
  input  logic [ipx_pkg::BYTE_W-1:0]   rdata,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ipx_pkg::status_t             out_status,
  output logic [ipx_pkg::BYTE_W-1:0]   out_byte,
  output logic [ipx_pkg::COUNT_W-1:0]  out_count
);
  import ipx_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  res_t              s1_res_r;
  logic              o_valid_r, o_valid_nxt;
  status_t           o_status_r;
  logic [BYTE_W-1:0] o_byte_r;
  logic [COUNT_W-1:0] o_count_r;
  logic              mv;

  assign mv       = s1_valid_r && (!o_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !o_valid_r || out_ready;

  always_comb begin
    s1_valid_nxt = acc ? 1'b1 : (mv ? 1'b0 : s1_valid_r);
    o_valid_nxt  = mv ? 1'b1 : (out_ready ? 1'b0 : o_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
    end
    if (mv) begin
      o_status_r <= s1_res_r.status;
      o_count_r  <= s1_res_r.count;
      o_byte_r   <= s1_res_r.is_byte ? rdata : '0;
    end
  end

  assign out_valid  = o_valid_r;
  assign out_status = o_status_r;
  assign out_byte   = o_byte_r;
  assign out_count  = o_count_r;

endmodule

// ===== rtl/iterated_page_expander.sv =====
// Iterated page expander: takes start/feed/pull transactions and returns one
// result transaction for each. A result passes through stage 1 and the
// output register before out_tvalid; one transaction per cycle sustained while
// out_tready is high, with a registered control update and store read.
// Reset (rst_n low, synchronous) clears phase, counters and pipeline valids;
// the pattern store is not cleared, every entry is written before it is read.
// Depends on ipx_pkg, ipx_ctrl, ipx_store, ipx_out.
module iterated_page_expander #(
  parameter int PAGE_BYTES = ipx_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // opcode
  input  logic [23:0] in_tdata,   // [15:0] src_len, [23:16] src_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // status
  output logic [23:0] out_tdata   // [7:0] out_byte, [20:8] out_count, rest zero
);
  import ipx_pkg::*;

  localparam int AW = $clog2(PAGE_BYTES);

  logic              acc;
  res_t              res;
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;
  status_t           o_status;
  logic [BYTE_W-1:0] o_byte;
  logic [COUNT_W-1:0] o_count;

  // A transaction enters whenever the first pipeline stage is empty or can hand on.
  assign acc = in_tvalid && in_tready;

  // Control: all page state is updated at the accepting edge, so the next
  // transaction sees it at once. Feeds in the pattern phase, and pulls there once
  // the source is used up, write the store; pulls in the emit phase issue a read at the current pattern position.
  ipx_ctrl #(.PAGE_BYTES(PAGE_BYTES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .opcode    (in_tuser),
    .src_len   (in_tdata[15:0]),
    .src_byte  (in_tdata[23:16]),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  // Pattern store. A write lands at one edge and a read of the same entry
  // can only come from a later transaction, so no forwarding is needed.
  ipx_store #(.PAGE_BYTES(PAGE_BYTES)) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Stage 1 lines the result up with the read data; the output register
  // holds the result while out_tready is low.
  ipx_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .res        (res),
    .rdata      (mem_rdata),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (o_status),
    .out_byte   (o_byte),
    .out_count  (o_count)
  );

  assign out_tuser = o_status;
  assign out_tdata = {3'b000, o_count, o_byte};

endmodule

// ===== rtl/ipx_checker.sv =====
// Port-level checks for iterated_page_expander, attached by bind.
// Depends on ipx_pkg and the top level's port list.
module ipx_checker #(
  parameter int PAGE_BYTES = ipx_pkg::PAGE_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [2:0]  out_tuser,
  input logic [23:0] out_tdata
);
  import ipx_pkg::*;

  // Nothing comes out the cycle after reset, and the input is open.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("result valid or input stalled right after reset");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Status code stays in range.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_ERROR)
    else $error("status out of range");

  // Only byte results carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_BYTE) |-> out_tdata[7:0] == 8'd0)
    else $error("byte set on non-byte result");

  // A byte result counts itself, checked while PAGE_BYTES < 8192 so the count fits.
  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_BYTE) && (PAGE_BYTES < 8192)
      |-> out_tdata[20:8] != 13'd0)
    else $error("byte result with zero count");

endmodule

bind iterated_page_expander ipx_checker #(.PAGE_BYTES(PAGE_BYTES)) u_ipx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
